/* rtl/pixdb_pkg.sv */
// Package for the pixel window to byte mapper: item kinds, control word,
// register indexes and fixed constants. No dependencies.
`timescale 1ns / 1ps

package pixdb_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_MODE   = 3'd5;

    // Gains are unsigned Q16.16.
    localparam int GAIN_W    = 32;
    localparam int GAIN_FRAC = 16;

    // Output limits.
    localparam logic [7:0] BYTE_MAX      = 8'd255;
    localparam logic [7:0] BYTE_MAX_MARK = 8'd254;
    localparam logic [7:0] BYTE_ZERO     = 8'd0;

    // Linear gain after reset is 1.0.
    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RESET = 32'h0001_0000;

    // What the back end must do with a word.
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_MARK,
        KIND_LIN,
        KIND_LOG
    } t_kind;

    // Control part of a classified word.
    typedef struct packed {
        t_kind kind;
        logic  lim254;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

/* rtl/pixdb_fifo.sv */
// Small register queue used between the front and back ends and at the output.
// Depends on nothing.
`timescale 1ns / 1ps

module pixdb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and count update with wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage for the queued words.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // The fill count never passes the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    // A push alone raises the count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count not raised on push");

    // A pop alone frees a slot.
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> !o_full)
        else $error("queue still full after pop");

endmodule

/* rtl/pixdb_front.sv */
// Front end: compares each pixel with the window and decides how it is mapped.
// Depends on pixdb_pkg.
`timescale 1ns / 1ps

module pixdb_front #(
    parameter int PIXEL_WIDTH     = 32,
    parameter int PIXEL_FRAC_BITS = 16
) (
    input  logic signed [PIXEL_WIDTH-1:0] i_pixel,
    input  logic signed [PIXEL_WIDTH-1:0] i_window_low,
    input  logic signed [PIXEL_WIDTH-1:0] i_window_high,
    input  logic                          i_log_mode,
    input  logic                          i_mark_mode,
    output pixdb_pkg::t_ctl               o_ctl,
    output logic [PIXEL_WIDTH-1:0]        o_val
);

    localparam logic signed [PIXEL_WIDTH:0] ONE = (PIXEL_WIDTH+1)'(1) << PIXEL_FRAC_BITS;

    logic signed [PIXEL_WIDTH:0] diff;
    logic                        below, above;

    assign diff  = (PIXEL_WIDTH+1)'(i_pixel) - (PIXEL_WIDTH+1)'(i_window_low);
    assign below = i_pixel < i_window_low;
    assign above = i_pixel > i_window_high;

    // Classify the pixel; the value carries the positive operand for the back end.
    always_comb begin
        o_ctl.lim254 = i_mark_mode;
        o_ctl.kind   = pixdb_pkg::KIND_ZERO;
        o_val        = PIXEL_WIDTH'(diff);
        if (!i_log_mode) begin
            if (i_mark_mode && (below || above)) begin
                o_ctl.kind = pixdb_pkg::KIND_MARK;
            end else if (diff > 0) begin
                o_ctl.kind = pixdb_pkg::KIND_LIN;
            end
        end else begin
            o_val = i_pixel;
            if (i_mark_mode && above) begin
                o_ctl.kind = pixdb_pkg::KIND_MARK;
            end else if ((PIXEL_WIDTH+1)'(i_pixel) > ONE) begin
                o_ctl.kind = pixdb_pkg::KIND_LOG;
            end
        end
    end

endmodule

/* rtl/pixdb_back.sv */
// Back end: linear product and pipelined log2 by repeated squaring, then
// gain, truncation and clamping. Depends on pixdb_pkg.
`timescale 1ns / 1ps

module pixdb_back #(
    parameter int PIXEL_WIDTH     = 32,
    parameter int PIXEL_FRAC_BITS = 16,
    parameter int LOG_FRAC_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_empty,
    input  pixdb_pkg::t_ctl                 i_ctl,
    input  logic [PIXEL_WIDTH-1:0]          i_val,
    output logic                            o_in_pop,
    input  logic [pixdb_pkg::GAIN_W-1:0]    i_linear_gain,
    input  logic [pixdb_pkg::GAIN_W-1:0]    i_log_gain,
    input  logic                            i_out_full,
    output logic                            o_out_push,
    output logic [7:0]                      o_byte_value,
    output logic                            o_marked
);

    localparam int PW    = PIXEL_WIDTH;
    localparam int GW    = pixdb_pkg::GAIN_W;
    localparam int PSW   = $clog2(PW);
    localparam int RW    = $clog2(PW - PIXEL_FRAC_BITS) + LOG_FRAC_BITS;
    localparam int LO_W  = PW / 2;
    localparam int HI_W  = PW - LO_W;
    localparam int FW    = PW + GW;
    localparam int LSH   = pixdb_pkg::GAIN_FRAC + PIXEL_FRAC_BITS;
    localparam int QW    = GW + RW;
    localparam int QSH   = pixdb_pkg::GAIN_FRAC + LOG_FRAC_BITS;
    localparam int NSTG  = LOG_FRAC_BITS;

    logic en;

    // Stage 1: leading-one position.
    logic            r_v1;
    pixdb_pkg::t_ctl r_ctl1;
    logic [PW-1:0]   r_val1;
    logic [PSW-1:0]  r_pos1;
    logic [PSW-1:0]  pos;

    // Stage 2: normalized mantissa and low partial product.
    logic            r_v2;
    pixdb_pkg::t_ctl r_ctl2;
    logic [PW-1:0]   r_val2;
    logic [31:0]     r_m2;
    logic [RW-1:0]   r_r2;
    logic [LO_W+GW-1:0] r_plo2;
    logic [PW+30:0]  norm_ext;

    // Stage 3: high partial product.
    logic            r_v3;
    pixdb_pkg::t_ctl r_ctl3;
    logic [31:0]     r_m3;
    logic [RW-1:0]   r_r3;
    logic [LO_W+GW-1:0] r_plo3;
    logic [HI_W+GW-1:0] r_phi3;

    // Linear combine and clamp.
    logic [FW-1:0]   lin_full;
    logic [FW-1:0]   lin_q;
    logic [7:0]      lin_limit;
    logic [7:0]      lin_byte;

    // Squaring chain; entry 0 is the stage after the linear clamp.
    logic            r_sv   [NSTG+1];
    pixdb_pkg::t_ctl r_sctl [NSTG+1];
    logic [31:0]     r_sm   [NSTG+1];
    logic [RW-1:0]   r_sr   [NSTG+1];
    logic [7:0]      r_slin [NSTG+1];

    // Gain stage.
    logic            r_vg;
    pixdb_pkg::t_ctl r_ctlg;
    logic [7:0]      r_ling;
    logic [QW-1:0]   r_qg;
    logic [QW-1:0]   log_q;
    logic [7:0]      log_limit;

    // The whole pipeline moves while the output queue has room.
    assign en       = !i_out_full;
    assign o_in_pop = en && !i_in_empty;

    // Leading-one search over the operand.
    always_comb begin
        pos = '0;
        for (int i = 0; i < PW; i++) begin
            if (i_val[i]) begin
                pos = PSW'(i);
            end
        end
    end

    assign norm_ext = {r_val1, 31'b0} >> r_pos1;

    assign lin_full  = (FW'(r_phi3) << LO_W) + FW'(r_plo3);
    assign lin_q     = lin_full >> LSH;
    assign lin_limit = r_ctl3.lim254 ? pixdb_pkg::BYTE_MAX_MARK : pixdb_pkg::BYTE_MAX;
    assign lin_byte  = (lin_q > FW'(lin_limit)) ? lin_limit : lin_q[7:0];

    // Front stages of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= !i_in_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl1 <= i_ctl;
            r_val1 <= i_val;
            r_pos1 <= pos;
            r_ctl2 <= r_ctl1;
            r_val2 <= r_val1;
            r_m2   <= norm_ext[31:0];
            r_r2   <= RW'(r_pos1) - RW'(PIXEL_FRAC_BITS);
            r_plo2 <= (LO_W+GW)'(r_val1[LO_W-1:0]) * (LO_W+GW)'(i_linear_gain);
            r_ctl3 <= r_ctl2;
            r_m3   <= r_m2;
            r_r3   <= r_r2;
            r_plo3 <= r_plo2;
            r_phi3 <= (HI_W+GW)'(r_val2[PW-1:LO_W]) * (HI_W+GW)'(i_linear_gain);
        end
    end

    // First entry of the squaring chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sctl[0] <= r_ctl3;
            r_sm[0]   <= r_m3;
            r_sr[0]   <= r_r3;
            r_slin[0] <= lin_byte;
        end
    end

    // One fraction bit per stage: square, test for 2.0, halve.
    for (genvar k = 0; k < NSTG; k++) begin : g_sq
        logic [63:0] sq_full;
        logic [32:0] sq;
        logic        bit_k;

        assign sq_full = 64'(r_sm[k]) * 64'(r_sm[k]);
        assign sq      = sq_full[63:31];
        assign bit_k   = sq[32];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sctl[k+1] <= r_sctl[k];
                r_slin[k+1] <= r_slin[k];
                r_sm[k+1]   <= bit_k ? sq[32:1] : sq[31:0];
                r_sr[k+1]   <= {r_sr[k][RW-2:0], bit_k};
            end
        end
    end

    // Log gain product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vg <= 1'b0;
        end else if (en) begin
            r_vg <= r_sv[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctlg <= r_sctl[NSTG];
            r_ling <= r_slin[NSTG];
            r_qg   <= QW'(i_log_gain) * QW'(r_sr[NSTG]);
        end
    end

    // Final selection of the byte by kind.
    assign log_q     = r_qg >> QSH;
    assign log_limit = r_ctlg.lim254 ? pixdb_pkg::BYTE_MAX_MARK : pixdb_pkg::BYTE_MAX;

    always_comb begin
        o_out_push   = en && r_vg;
        o_byte_value = pixdb_pkg::BYTE_ZERO;
        o_marked     = 1'b0;
        case (r_ctlg.kind)
            pixdb_pkg::KIND_MARK: begin
                o_byte_value = pixdb_pkg::BYTE_MAX;
                o_marked     = 1'b1;
            end
            pixdb_pkg::KIND_LIN: begin
                o_byte_value = r_ling;
            end
            pixdb_pkg::KIND_LOG: begin
                o_byte_value = (log_q > QW'(log_limit)) ? log_limit : log_q[7:0];
            end
            default: begin
                o_byte_value = pixdb_pkg::BYTE_ZERO;
            end
        endcase
    end

endmodule

/* rtl/pixel_window_to_byte.sv */
// Top level of the pixel window to byte mapper: registers, front end, queues
// and back end. Depends on pixdb_pkg, pixdb_front, pixdb_fifo, pixdb_back.
`timescale 1ns / 1ps

// Maps one signed fixed-point pixel to a display byte in linear or log mode,
// with optional marking of out-of-window pixels (in log mode, above only). One
// pixel is taken per clock while the input queue has room, and one byte leaves
// per clock while the output is popped and not empty. Squaring stages in a
// chain find one log2 fraction bit each; the linear product travels alongside.
// Four-word queues sit between the front and back ends and at the output.
// The user must write configuration only while the block is idle (unchecked).
module pixel_window_to_byte #(
    parameter int PIXEL_FRAC_BITS = 16,
    parameter int PIXEL_WIDTH     = 32,
    parameter int LOG_FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [PIXEL_WIDTH-1:0]        i_pixel,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [7:0]                           o_byte_value,
    output logic                                 o_marked,
    input  logic                                 i_cfg_we,
    input  logic [pixdb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [((PIXEL_WIDTH > 32) ? PIXEL_WIDTH : 32)-1:0] i_cfg_data
);

    localparam int PW    = PIXEL_WIDTH;
    localparam int GW    = pixdb_pkg::GAIN_W;
    localparam int CTL_W = pixdb_pkg::CTL_W;
    localparam int MQ_W  = CTL_W + PW;
    localparam int OQ_W  = 9;
    localparam int QDEPTH = 4;

    logic signed [PW-1:0] r_window_low;
    logic signed [PW-1:0] r_window_high;
    logic [GW-1:0]        r_linear_gain;
    logic [GW-1:0]        r_log_gain;
    logic                 r_log_mode;
    logic                 r_mark_mode;

    pixdb_pkg::t_ctl      f_ctl;
    logic [PW-1:0]        f_val;
    logic [MQ_W-1:0]      mq_rd;
    logic                 mq_empty;
    logic                 mq_pop;
    pixdb_pkg::t_ctl      b_ctl;
    logic [PW-1:0]        b_val;
    logic                 oq_full;
    logic                 oq_push;
    logic [7:0]           b_byte;
    logic                 b_marked;
    logic [OQ_W-1:0]      oq_rd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_low  <= '0;
            r_window_high <= PW'(255) << PIXEL_FRAC_BITS;
            r_linear_gain <= pixdb_pkg::LINEAR_GAIN_RESET;
            r_log_gain    <= '0;
            r_log_mode    <= 1'b0;
            r_mark_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pixdb_pkg::REG_WINDOW_LOW:  r_window_low  <= i_cfg_data[PW-1:0];
                pixdb_pkg::REG_WINDOW_HIGH: r_window_high <= i_cfg_data[PW-1:0];
                pixdb_pkg::REG_LINEAR_GAIN: r_linear_gain <= i_cfg_data[GW-1:0];
                pixdb_pkg::REG_LOG_GAIN:    r_log_gain    <= i_cfg_data[GW-1:0];
                pixdb_pkg::REG_LOG_MODE:    r_log_mode    <= i_cfg_data[0];
                pixdb_pkg::REG_MARK_MODE:   r_mark_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Classification of each incoming pixel.
    pixdb_front #(
        .PIXEL_WIDTH     (PIXEL_WIDTH),
        .PIXEL_FRAC_BITS (PIXEL_FRAC_BITS)
    ) u_front (
        .i_pixel       (i_pixel),
        .i_window_low  (r_window_low),
        .i_window_high (r_window_high),
        .i_log_mode    (r_log_mode),
        .i_mark_mode   (r_mark_mode),
        .o_ctl         (f_ctl),
        .o_val         (f_val)
    );

    // Queue between front and back ends.
    pixdb_fifo #(
        .W     (MQ_W),
        .DEPTH (QDEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_val}),
        .o_full  (full),
        .i_pop   (mq_pop),
        .o_data  (mq_rd),
        .o_empty (mq_empty)
    );

    assign b_ctl = pixdb_pkg::t_ctl'(mq_rd[MQ_W-1:PW]);
    assign b_val = mq_rd[PW-1:0];

    // Arithmetic pipeline.
    pixdb_back #(
        .PIXEL_WIDTH     (PIXEL_WIDTH),
        .PIXEL_FRAC_BITS (PIXEL_FRAC_BITS),
        .LOG_FRAC_BITS   (LOG_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_empty    (mq_empty),
        .i_ctl         (b_ctl),
        .i_val         (b_val),
        .o_in_pop      (mq_pop),
        .i_linear_gain (r_linear_gain),
        .i_log_gain    (r_log_gain),
        .i_out_full    (oq_full),
        .o_out_push    (oq_push),
        .o_byte_value  (b_byte),
        .o_marked      (b_marked)
    );

    // Result queue toward the consumer.
    pixdb_fifo #(
        .W     (OQ_W),
        .DEPTH (QDEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  ({b_marked, b_byte}),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_rd),
        .o_empty (empty)
    );

    assign o_byte_value = oq_rd[7:0];
    assign o_marked     = oq_rd[8];

endmodule

/* sim/tb_pixel_window_to_byte.sv */
// Self-checking testbench for pixel_window_to_byte: directed words from a table,
// then random configurations and pixels, checked against a bit-accurate predictor.
// Depends on rtl/pixdb_pkg.sv and rtl/pixel_window_to_byte.sv.
`timescale 1ns / 1ps

module tb_pixel_window_to_byte;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int WDOG_LIMIT   = 3000;
    localparam int RAND_PHASES  = 8;
    localparam int RAND_WORDS   = 116;

    // Indexes past the last register; writes to them are dropped.
    localparam logic [pixdb_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [pixdb_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    // One expected output word.
    typedef struct {
        logic [7:0] byte_value;
        logic       marked;
    } t_byte_word;

    // One row of the directed table.
    typedef struct {
        int          phase;
        logic [31:0] pixel;
        bit          typed;
        logic [7:0]  byte_value;
        logic        marked;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic signed [31:0] i_pixel = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_byte_value;
    logic        o_marked;
    logic        i_cfg_we = 1'b0;
    logic [pixdb_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic signed [31:0] win_low;
    logic signed [31:0] win_high;
    logic [31:0] lin_gain;
    logic [31:0] lg_gain;
    logic        is_log;
    logic        is_mark;

    t_byte_word  pending_bytes[$];
    t_dir_row    dir_rows[$];
    int          err_cnt = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;

    pixel_window_to_byte u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_pixel      (i_pixel),
        .empty        (empty),
        .pop          (pop),
        .o_byte_value (o_byte_value),
        .o_marked     (o_marked),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Maps one pixel to its display byte under the current configuration.
    function automatic t_byte_word map_pixel(logic signed [31:0] px);
        logic signed [63:0] p;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic signed [63:0] diff;
        logic [127:0] prod;
        logic [63:0] lim;
        logic [63:0] q;
        logic [63:0] mant;
        logic [63:0] lg;
        int pos;
        t_byte_word w;
        p = px;
        lo = win_low;
        hi = win_high;
        lim = is_mark ? 64'd254 : 64'd255;
        w.byte_value = pixdb_pkg::BYTE_ZERO;
        w.marked = 1'b0;
        if (!is_log) begin
            if (is_mark && (p < lo || p > hi)) begin
                w.byte_value = pixdb_pkg::BYTE_MAX;
                w.marked = 1'b1;
            end else begin
                diff = p - lo;
                if (diff > 0) begin
                    prod = {64'd0, diff} * {96'd0, lin_gain};
                    prod = prod >> 32;
                    w.byte_value = (prod > {64'd0, lim}) ? lim[7:0] : prod[7:0];
                end
            end
        end else begin
            if (is_mark && p > hi) begin
                w.byte_value = pixdb_pkg::BYTE_MAX;
                w.marked = 1'b1;
            end else if (p > 64'sd65536) begin
                // Integer part from the leading one, then one fraction bit per square.
                pos = 0;
                for (int i = 0; i < 32; i++)
                    if (px[i]) pos = i;
                mant = {32'd0, px};
                mant = (pos >= 31) ? (mant >> (pos - 31)) : (mant << (31 - pos));
                lg = 64'(pos - 16);
                for (int i = 0; i < 16; i++) begin
                    mant = (mant * mant) >> 31;
                    lg = lg << 1;
                    if (mant >= 64'h1_0000_0000) begin
                        lg = lg | 64'd1;
                        mant = mant >> 1;
                    end
                end
                q = ({32'd0, lg_gain} * lg) >> 32;
                w.byte_value = (q > lim) ? lim[7:0] : q[7:0];
            end
        end
        return w;
    endfunction

    // Writes one register and keeps the shadow copy in step. Call at a clock edge.
    task automatic cfg_write(logic [pixdb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            pixdb_pkg::REG_WINDOW_LOW:  win_low = data;
            pixdb_pkg::REG_WINDOW_HIGH: win_high = data;
            pixdb_pkg::REG_LINEAR_GAIN: lin_gain = data;
            pixdb_pkg::REG_LOG_GAIN:    lg_gain = data;
            pixdb_pkg::REG_LOG_MODE:    is_log = data[0];
            pixdb_pkg::REG_MARK_MODE:   is_mark = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one pixel after a random gap and records its expected byte.
    task automatic send_pixel(logic [31:0] px, bit typed, t_byte_word typed_word);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (full);
        pending_bytes.push_back(typed ? typed_word : map_pixel(px));
    endtask

    // Stops offering and waits until every expected byte has come out.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return win_low + 32'($urandom_range(0, 64)) - 32'd32;
            2: return win_high + 32'($urandom_range(0, 64)) - 32'd32;
            3: return $urandom_range(0, 32'h00FF_FFFF);
            default: return 32'h0001_0000 + 32'($urandom_range(0, 8)) - 32'd4;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0100_0000);
            2: return $urandom_range(0, 32'h0002_0000);
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    task automatic add_row(int ph, logic [31:0] px, bit typed, logic [7:0] b, logic mk);
        t_dir_row r;
        r.phase = ph;
        r.pixel = px;
        r.typed = typed;
        r.byte_value = b;
        r.marked = mk;
        dir_rows.push_back(r);
    endtask

    // Output side: random stalls, one long hold on request, and the word check.
    initial begin
        int n;
        t_byte_word want;
        @(posedge i_rst_n);
        forever begin
            n = $urandom_range(0, 8);
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (n > 0) begin
                pop <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected word byte=%0d marked=%0b",
                         $time, o_byte_value, o_marked);
                err_cnt++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_byte_value !== want.byte_value || o_marked !== want.marked) begin
                    $display("%0t: mismatch expected byte=%0d marked=%0b actual byte=%0d marked=%0b",
                             $time, want.byte_value, want.marked, o_byte_value, o_marked);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("pixel_window_to_byte test failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial begin
        int cur_phase;
        t_byte_word tw;
        win_low = '0;
        win_high = 32'h00FF_0000;
        lin_gain = pixdb_pkg::LINEAR_GAIN_RESET;
        lg_gain = '0;
        is_log = 1'b0;
        is_mark = 1'b0;

        // Values after reset: plain linear with unit gain over 0..255.
        add_row(0, 32'h0000_0000, 1, 8'd0, 1'b0);
        add_row(0, 32'h000A_0000, 1, 8'd10, 1'b0);
        add_row(0, 32'h000A_FFFF, 1, 8'd10, 1'b0);
        add_row(0, 32'h8000_0000, 1, 8'd0, 1'b0);
        add_row(0, 32'h7FFF_FFFF, 1, 8'd255, 1'b0);
        add_row(0, 32'hFFFF_FFFF, 1, 8'd0, 1'b0);
        // Linear marking around the window 10..20.
        add_row(1, 32'h0009_FFFF, 1, 8'd255, 1'b1);
        add_row(1, 32'h000A_0000, 0, 8'd0, 1'b0);
        add_row(1, 32'h000F_0000, 0, 8'd0, 1'b0);
        add_row(1, 32'h0014_0000, 0, 8'd0, 1'b0);
        add_row(1, 32'h0014_0001, 1, 8'd255, 1'b1);
        // Reversed bounds: every pixel is marked.
        add_row(2, 32'h000F_0000, 1, 8'd255, 1'b1);
        add_row(2, 32'h0005_0000, 1, 8'd255, 1'b1);
        add_row(2, 32'h0019_0000, 1, 8'd255, 1'b1);
        // Log mapping, including pixels at and just above 1.0.
        add_row(3, 32'h0001_0000, 1, 8'd0, 1'b0);
        add_row(3, 32'h0001_0001, 0, 8'd0, 1'b0);
        add_row(3, 32'h0002_0000, 0, 8'd0, 1'b0);
        add_row(3, 32'h7FFF_FFFF, 0, 8'd0, 1'b0);
        add_row(3, 32'h8000_0000, 1, 8'd0, 1'b0);
        add_row(3, 32'h0000_0000, 1, 8'd0, 1'b0);
        // Log marking with an upper bound below 1.0.
        add_row(4, 32'h0000_C000, 1, 8'd255, 1'b1);
        add_row(4, 32'h0000_4000, 1, 8'd0, 1'b0);
        add_row(4, 32'h0003_0000, 1, 8'd255, 1'b1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_phase = 0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].phase != cur_phase) begin
                wait_idle();
                cur_phase = dir_rows[k].phase;
                case (cur_phase)
                    1: begin
                        // Writes past the last register must be ignored.
                        cfg_write(REG_UNUSED_A, 32'hDEAD_BEEF);
                        cfg_write(REG_UNUSED_B, 32'h1234_5678);
                        cfg_write(pixdb_pkg::REG_MARK_MODE, 32'hFFFF_FFFF);
                        cfg_write(pixdb_pkg::REG_WINDOW_LOW, 32'h000A_0000);
                        cfg_write(pixdb_pkg::REG_WINDOW_HIGH, 32'h0014_0000);
                        cfg_write(pixdb_pkg::REG_LINEAR_GAIN, 32'd1664614);
                    end
                    2: begin
                        cfg_write(pixdb_pkg::REG_WINDOW_LOW, 32'h0014_0000);
                        cfg_write(pixdb_pkg::REG_WINDOW_HIGH, 32'h000A_0000);
                        cfg_write(pixdb_pkg::REG_LINEAR_GAIN, 32'hFFFF_FFFF);
                    end
                    3: begin
                        cfg_write(pixdb_pkg::REG_MARK_MODE, 32'hFFFF_FFFE);
                        cfg_write(pixdb_pkg::REG_LOG_MODE, 32'h0000_0003);
                        cfg_write(pixdb_pkg::REG_LOG_GAIN, 32'h0010_0000);
                        cfg_write(pixdb_pkg::REG_WINDOW_HIGH, 32'h7FFF_FFFF);
                    end
                    default: begin
                        cfg_write(pixdb_pkg::REG_MARK_MODE, 32'h0000_0001);
                        cfg_write(pixdb_pkg::REG_WINDOW_HIGH, 32'h0000_8000);
                        cfg_write(pixdb_pkg::REG_LOG_GAIN, 32'hFFFF_FFFF);
                    end
                endcase
                cfg_done();
            end
            tw.byte_value = dir_rows[k].byte_value;
            tw.marked = dir_rows[k].marked;
            send_pixel(dir_rows[k].pixel, dir_rows[k].typed, tw);
        end

        // Random phases: mode follows the phase, first two use extreme settings.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            if (ph == 0) begin
                cfg_write(pixdb_pkg::REG_WINDOW_LOW, 32'h8000_0000);
                cfg_write(pixdb_pkg::REG_WINDOW_HIGH, 32'h7FFF_FFFF);
                cfg_write(pixdb_pkg::REG_LINEAR_GAIN, 32'hFFFF_FFFF);
                cfg_write(pixdb_pkg::REG_LOG_GAIN, 32'hFFFF_FFFF);
            end else if (ph == 1) begin
                cfg_write(pixdb_pkg::REG_WINDOW_LOW, 32'h7FFF_FFFF);
                cfg_write(pixdb_pkg::REG_WINDOW_HIGH, 32'h8000_0000);
                cfg_write(pixdb_pkg::REG_LINEAR_GAIN, 32'h0);
                cfg_write(pixdb_pkg::REG_LOG_GAIN, 32'h0);
            end else begin
                cfg_write(pixdb_pkg::REG_WINDOW_LOW, $urandom_range(0, 1) ? $urandom
                          : 32'($urandom_range(0, 32'h00FF_FFFF)));
                cfg_write(pixdb_pkg::REG_WINDOW_HIGH,
                          win_low + $urandom_range(0, 32'h00FF_FFFF));
                cfg_write(pixdb_pkg::REG_LINEAR_GAIN, pick_gain());
                cfg_write(pixdb_pkg::REG_LOG_GAIN, pick_gain());
            end
            cfg_write(pixdb_pkg::REG_LOG_MODE, 32'(ph[1]));
            cfg_write(pixdb_pkg::REG_MARK_MODE, 32'(ph[0]));
            cfg_done();
            if (ph == 2) hold_req = 1'b1;
            for (int k = 0; k < RAND_WORDS; k++) begin
                if (ph == 3 && k == RAND_WORDS / 2) begin
                    // Let the pipeline run dry in the middle of a phase.
                    push <= 1'b0;
                    while (pending_bytes.size() != 0) @(posedge i_clk);
                end
                send_pixel(pick_pixel(), 0, tw);
            end
        end

        wait_idle();
        if (err_cnt == 0)
            $display("pixel_window_to_byte test passed");
        else
            $display("pixel_window_to_byte test failed");
        $finish;
    end

endmodule
